>>> hdl/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// shared types, character codes and register layout of the terminal line
// discipline
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam int LINE_LENGTH_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CTRL_OFFSET = 8'h40;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;

  localparam logic [23:0] ERASE_ECHO = 24'h082008;

  localparam int IM_IGNCR = 0;
  localparam int IM_ICRNL = 1;
  localparam int IM_INLCR = 2;

  localparam int LM_ECHO   = 0;
  localparam int LM_ECHOCTL = 1;
  localparam int LM_ISIG   = 2;
  localparam int LM_ICANON = 3;

  localparam logic [1:0] SIG_INTR = 2'd0;
  localparam logic [1:0] SIG_QUIT = 2'd1;
  localparam logic [1:0] SIG_SUSP = 2'd2;

  localparam logic [2:0]  INPUT_MODES_RST  = 3'd2;
  localparam logic [3:0]  LOCAL_MODES_RST  = 4'd15;
  localparam logic [23:0] SIGNAL_CHARS_RST = 24'h1A1C03;
  localparam logic [15:0] EDIT_CHARS_RST   = 16'h1508;
  localparam logic [23:0] END_CHARS_RST    = 24'h000004;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_MODES  = 3'd0,
    REG_LOCAL_MODES  = 3'd1,
    REG_SIGNAL_CHARS = 3'd2,
    REG_EDIT_CHARS   = 3'd3,
    REG_END_CHARS    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  input_modes;
    logic [3:0]  local_modes;
    logic [23:0] signal_chars;
    logic [15:0] edit_chars;
    logic [23:0] end_chars;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN
  } seq_state_t;

  typedef enum logic [1:0] {
    RUN_SINGLE,
    RUN_ERASE,
    RUN_RELEASE
  } run_kind_t;

  typedef struct packed {
    logic [1:0]  echo_count;
    logic [23:0] echo_bytes;
    logic        deliver_valid;
    logic [7:0]  deliver_byte;
    logic        signal_valid;
    logic [1:0]  signal_kind;
    logic        last;
  } result_t;

endpackage

>>> hdl/tld_cfg_regs.sv
// ----------------------------------------------------------------------------
// tld_cfg_regs
// mode and special character registers, written through the config port
// ----------------------------------------------------------------------------
module tld_cfg_regs
  import tld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_INPUT_MODES:  cfg_nxt.input_modes  = wr_data[2:0];
        REG_LOCAL_MODES:  cfg_nxt.local_modes  = wr_data[3:0];
        REG_SIGNAL_CHARS: cfg_nxt.signal_chars = wr_data[23:0];
        REG_EDIT_CHARS:   cfg_nxt.edit_chars   = wr_data[15:0];
        REG_END_CHARS:    cfg_nxt.end_chars    = wr_data[23:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_modes  <= INPUT_MODES_RST;
      cfg_r.local_modes  <= LOCAL_MODES_RST;
      cfg_r.signal_chars <= SIGNAL_CHARS_RST;
      cfg_r.edit_chars   <= EDIT_CHARS_RST;
      cfg_r.end_chars    <= END_CHARS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/tld_line_ram.sv
// ----------------------------------------------------------------------------
// tld_line_ram
// line store, one write and one registered read port
// ----------------------------------------------------------------------------
module tld_line_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/tld_seq.sv
// ----------------------------------------------------------------------------
// tld_seq
// decodes one received byte and sequences its result words, reading the
// line store one entry per cycle on a release while the output is not stalled
// ----------------------------------------------------------------------------
module tld_seq
  import tld_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF,
  parameter int AW          = $clog2(LINE_LENGTH),
  parameter int LW          = $clog2(LINE_LENGTH + 1),
  parameter int CW          = $clog2(LINE_LENGTH + 3)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output result_t       out_res,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output logic [7:0]    mem_wr_data,
  output logic [AW-1:0] mem_rd_addr,
  input  logic [7:0]    mem_rd_data
);

  seq_state_t state_r, state_nxt;

  logic [7:0]    byte_r;
  logic [7:0]    c_r, c_nxt;
  logic [LW-1:0] len_r, len_nxt;
  run_kind_t     kind_r, kind_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    head_cnt_r, head_cnt_nxt;
  logic [23:0]   head_bytes_r, head_bytes_nxt;
  logic          dv_r, dv_nxt;
  logic [7:0]    db_r, db_nxt;
  logic          sv_r, sv_nxt;
  logic [1:0]    sk_r, sk_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       out_res_r, out_res_nxt;

  logic          do_decode;
  logic          do_load;
  logic          slot_free;
  result_t       res;

  // decode
  logic [7:0]    c;
  logic          ign, echo, caret, sig_hit, is_erase, is_kill, rel_match, wr_d;
  logic [1:0]    sig_kind;
  logic [23:0]   caret_bytes;
  logic [1:0]    plain_cnt;
  logic [23:0]   plain_bytes;
  logic [CW-1:0] n_erase;
  logic [LW-1:0] len_inc;

  always_comb begin
    c = byte_r;
    if (byte_r == CH_CR && cfg.input_modes[IM_ICRNL]) begin
      c = CH_NL;
    end else if (byte_r == CH_NL && cfg.input_modes[IM_INLCR]) begin
      c = CH_CR;
    end
    ign   = (byte_r == CH_CR) && cfg.input_modes[IM_IGNCR];
    echo  = cfg.local_modes[LM_ECHO];
    caret = echo && cfg.local_modes[LM_ECHOCTL] && (c < CTRL_LIMIT) &&
            (c != CH_NL) && (c != CH_CR) && (c != CH_BS) && (c != CH_TAB) &&
            (c != CH_ESC);
    caret_bytes = {8'h00, c + CTRL_OFFSET, CH_CARET};

    sig_hit  = 1'b0;
    sig_kind = SIG_INTR;
    if (cfg.local_modes[LM_ISIG]) begin
      if (c == cfg.signal_chars[7:0]) begin
        sig_hit  = 1'b1;
        sig_kind = SIG_INTR;
      end else if (c == cfg.signal_chars[15:8]) begin
        sig_hit  = 1'b1;
        sig_kind = SIG_QUIT;
      end else if (c == cfg.signal_chars[23:16]) begin
        sig_hit  = 1'b1;
        sig_kind = SIG_SUSP;
      end
    end

    is_erase  = (c == cfg.edit_chars[7:0]);
    is_kill   = (c == cfg.edit_chars[15:8]);
    rel_match = (c == cfg.end_chars[7:0]) || (c == CH_NL) ||
                (c == cfg.end_chars[15:8]) || (c == cfg.end_chars[23:16]);
    len_inc   = len_r + LW'(1);

    if (is_erase) begin
      n_erase = (len_r != '0 && echo) ? CW'(1) : '0;
    end else if (echo) begin
      n_erase = CW'(len_r) + (cfg.local_modes[LM_ECHOCTL] ? CW'(2) : CW'(0));
    end else begin
      n_erase = '0;
    end

    if (caret) begin
      plain_cnt   = 2'd2;
      plain_bytes = caret_bytes;
    end else if (echo) begin
      plain_cnt   = 2'd1;
      plain_bytes = {16'h0000, c};
    end else begin
      plain_cnt   = 2'd0;
      plain_bytes = '0;
    end
  end

  // plan of the result run for the decoded byte
  always_comb begin
    kind_nxt       = kind_r;
    total_nxt      = total_r;
    head_cnt_nxt   = head_cnt_r;
    head_bytes_nxt = head_bytes_r;
    dv_nxt         = dv_r;
    db_nxt         = db_r;
    sv_nxt         = sv_r;
    sk_nxt         = sk_r;
    c_nxt          = c_r;
    len_nxt        = len_r;
    wr_d           = 1'b0;
    if (do_decode) begin
      kind_nxt       = RUN_SINGLE;
      total_nxt      = CW'(1);
      head_cnt_nxt   = caret ? 2'd2 : 2'd0;
      head_bytes_nxt = caret ? caret_bytes : '0;
      dv_nxt         = 1'b0;
      db_nxt         = '0;
      sv_nxt         = 1'b0;
      sk_nxt         = '0;
      c_nxt          = c;
      if (ign) begin
        head_cnt_nxt   = 2'd0;
        head_bytes_nxt = '0;
      end else if (sig_hit) begin
        sv_nxt = 1'b1;
        sk_nxt = sig_kind;
      end else if (cfg.local_modes[LM_ICANON]) begin
        if (is_erase || is_kill) begin
          if (n_erase != '0) begin
            kind_nxt       = RUN_ERASE;
            total_nxt      = n_erase + CW'(caret);
            head_cnt_nxt   = caret ? 2'd2 : 2'd3;
            head_bytes_nxt = caret ? caret_bytes : ERASE_ECHO;
          end
          if (is_erase) begin
            len_nxt = (len_r != '0) ? len_r - LW'(1) : len_r;
          end else begin
            len_nxt = '0;
          end
        end else begin
          head_cnt_nxt   = plain_cnt;
          head_bytes_nxt = plain_bytes;
          wr_d           = 1'b1;
          if (rel_match || len_inc == LW'(LINE_LENGTH)) begin
            kind_nxt  = RUN_RELEASE;
            total_nxt = CW'(len_inc);
            len_nxt   = '0;
          end else begin
            len_nxt = len_inc;
          end
        end
      end else begin
        head_cnt_nxt   = plain_cnt;
        head_bytes_nxt = plain_bytes;
        dv_nxt         = 1'b1;
        db_nxt         = c;
      end
    end
  end

  // current result word of the run
  always_comb begin
    res = '0;
    res.last = (idx_r == total_r - CW'(1));
    if (idx_r == '0) begin
      res.echo_count = head_cnt_r;
      res.echo_bytes = head_bytes_r;
    end else if (kind_r == RUN_ERASE) begin
      res.echo_count = 2'd3;
      res.echo_bytes = ERASE_ECHO;
    end
    if (kind_r == RUN_RELEASE) begin
      res.deliver_valid = 1'b1;
      res.deliver_byte  = res.last ? c_r : mem_rd_data;
    end else begin
      res.deliver_valid = dv_r;
      res.deliver_byte  = db_r;
    end
    res.signal_valid = sv_r;
    res.signal_kind  = sk_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = ST_RUN;
      ST_RUN:    if (slot_free && res.last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    do_decode = 1'b0;
    do_load   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_DECODE: do_decode = 1'b1;
      ST_RUN:    do_load = slot_free;
      default:   in_stall = 1'b1;
    endcase
  end

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    idx_nxt = idx_r;
    if (do_decode) begin
      idx_nxt = '0;
    end else if (do_load && !res.last) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (do_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
    end
    c_r          <= c_nxt;
    kind_r       <= kind_nxt;
    total_r      <= total_nxt;
    idx_r        <= idx_nxt;
    head_cnt_r   <= head_cnt_nxt;
    head_bytes_r <= head_bytes_nxt;
    dv_r         <= dv_nxt;
    db_r         <= db_nxt;
    sv_r         <= sv_nxt;
    sk_r         <= sk_nxt;
    out_res_r    <= out_res_nxt;
  end

  // store is read one entry ahead of the word being formed
  assign mem_rd_addr = (idx_nxt < CW'(LINE_LENGTH)) ? idx_nxt[AW-1:0] : '0;
  assign mem_wr_en   = do_decode && wr_d;
  assign mem_wr_addr = len_r[AW-1:0];
  assign mem_wr_data = c;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> hdl/terminal_line_discipline.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline
// receive side of a terminal line discipline: input translation, echo,
// signal characters and canonical line editing over a line store
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_rx_byte
//   out      output     out_valid/out_stall echo, deliver, signal, last
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// an item is accepted, then decoded, then its result words go out one per cycle
// while the output does not stall, paced by the single line store read port
// a release or kill gives up to LINE_LENGTH + 2 words
// reset empties the line; the store itself is not cleared
// a stalled output holds its word and the sequencer waits on it
// ----------------------------------------------------------------------------
module terminal_line_discipline
  import tld_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_echo_count,
  output logic [23:0]           out_echo_bytes,
  output logic                  out_deliver_valid,
  output logic [7:0]            out_deliver_byte,
  output logic                  out_signal_valid,
  output logic [1:0]            out_signal_kind,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(LINE_LENGTH);

  cfg_t          cfg;
  result_t       res;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  assign cfg_ready = 1'b1;

  tld_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tld_line_ram #(
    .DEPTH (LINE_LENGTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  tld_seq #(
    .LINE_LENGTH (LINE_LENGTH),
    .AW          (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  assign out_echo_count    = res.echo_count;
  assign out_echo_bytes    = res.echo_bytes;
  assign out_deliver_valid = res.deliver_valid;
  assign out_deliver_byte  = res.deliver_byte;
  assign out_signal_valid  = res.signal_valid;
  assign out_signal_kind   = res.signal_kind;
  assign out_last          = res.last;

`ifndef SYNTHESIS
  // busy right after taking a word
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while the sequencer was still busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_deliver_valid && out_signal_valid))
    else $error("delivery and signal in the same word");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_signal_valid) |-> out_last)
    else $error("signal word is not the final word of its byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_echo_count == 2'd0) |-> (out_echo_bytes == 24'h000000))
    else $error("echo bytes set with an empty echo count");
`endif

endmodule

>>> bench/line_discipline_checker.sv
// ----------------------------------------------------------------------------
// line_discipline_checker
// Watches the input, result and register ports of the terminal line
// discipline. It keeps its own copy of the mode registers and the line
// buffer, works out the result words that each accepted byte must give,
// and checks every result word, field by field, against the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module line_discipline_checker
  import tld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            out_echo_count,
  input  logic [23:0]           out_echo_bytes,
  input  logic                  out_deliver_valid,
  input  logic [7:0]            out_deliver_byte,
  input  logic                  out_signal_valid,
  input  logic [1:0]            out_signal_kind,
  input  logic                  out_last,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t       modes;
  logic [7:0] line_buf [LINE_LENGTH_DEF];
  int         line_fill;
  int         echo_fill;
  logic [23:0] echo_acc;
  result_t    byte_words [$];
  result_t    expected_words [$];

  task automatic push_word(input logic dv, input logic [7:0] db, input logic sv,
                           input logic [1:0] sk);
    result_t w;
    w.echo_count    = echo_fill[1:0];
    w.echo_bytes    = echo_acc;
    w.deliver_valid = dv;
    w.deliver_byte  = db;
    w.signal_valid  = sv;
    w.signal_kind   = sk;
    w.last          = 1'b0;
    byte_words.push_back(w);
    echo_fill = 0;
    echo_acc  = '0;
  endtask

  task automatic queue_echo(input int n, input logic [23:0] bytes);
    if (echo_fill + n > 3) push_word(1'b0, 8'h00, 1'b0, '0);
    echo_acc  = echo_acc | (bytes << (8 * echo_fill));
    echo_fill = echo_fill + n;
  endtask

  task automatic edit_line(input logic [7:0] c, input logic echo_on, input logic caret);
    logic release_line;
    int   erases;
    if (c == modes.edit_chars[7:0]) begin
      if (line_fill > 0) begin
        line_fill--;
        if (echo_on) queue_echo(3, ERASE_ECHO);
      end
    end else if (c == modes.edit_chars[15:8]) begin
      if (echo_on) begin
        erases = line_fill + (modes.local_modes[LM_ECHOCTL] ? 2 : 0);
        repeat (erases) queue_echo(3, ERASE_ECHO);
      end
      line_fill = 0;
    end else begin
      release_line = (c == modes.end_chars[7:0]) || (c == CH_NL) ||
                     (c == modes.end_chars[15:8]) || (c == modes.end_chars[23:16]);
      if (echo_on && !caret) queue_echo(1, {16'h0000, c});
      line_buf[line_fill] = c;
      line_fill++;
      if (line_fill >= LINE_LENGTH_DEF) release_line = 1'b1;
      if (release_line) begin
        for (int k = 0; k < line_fill; k++) push_word(1'b1, line_buf[k], 1'b0, '0);
        line_fill = 0;
      end
    end
  endtask

  task automatic discipline_byte(input logic [7:0] rx);
    logic [7:0] c;
    logic       echo_on;
    logic       caret;
    logic       sig_hit;
    logic [1:0] sig_kind;
    c = rx;
    byte_words.delete();
    echo_fill = 0;
    echo_acc  = '0;
    if (!(c == CH_CR && modes.input_modes[IM_IGNCR])) begin
      if (c == CH_CR && modes.input_modes[IM_ICRNL]) c = CH_NL;
      else if (c == CH_NL && modes.input_modes[IM_INLCR]) c = CH_CR;
      echo_on = modes.local_modes[LM_ECHO];
      caret = echo_on && modes.local_modes[LM_ECHOCTL] && (c < CTRL_LIMIT) &&
              c != CH_NL && c != CH_CR && c != CH_BS && c != CH_TAB && c != CH_ESC;
      if (caret) queue_echo(2, {8'h00, c + CTRL_OFFSET, CH_CARET});
      sig_hit  = 1'b0;
      sig_kind = SIG_INTR;
      if (modes.local_modes[LM_ISIG]) begin
        if (c == modes.signal_chars[7:0]) begin
          sig_hit  = 1'b1;
          sig_kind = SIG_INTR;
        end else if (c == modes.signal_chars[15:8]) begin
          sig_hit  = 1'b1;
          sig_kind = SIG_QUIT;
        end else if (c == modes.signal_chars[23:16]) begin
          sig_hit  = 1'b1;
          sig_kind = SIG_SUSP;
        end
      end
      if (sig_hit) begin
        push_word(1'b0, 8'h00, 1'b1, sig_kind);
      end else if (modes.local_modes[LM_ICANON]) begin
        edit_line(c, echo_on, caret);
      end else begin
        if (echo_on && !caret) queue_echo(1, {16'h0000, c});
        push_word(1'b1, c, 1'b0, '0);
      end
    end
    if (echo_fill > 0 || byte_words.size() == 0) push_word(1'b0, 8'h00, 1'b0, '0);
    byte_words[byte_words.size() - 1].last = 1'b1;
    foreach (byte_words[k]) expected_words.push_back(byte_words[k]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_INPUT_MODES:  modes.input_modes  = data[2:0];
      REG_LOCAL_MODES:  modes.local_modes  = data[3:0];
      REG_SIGNAL_CHARS: modes.signal_chars = data[23:0];
      REG_EDIT_CHARS:   modes.edit_chars   = data[15:0];
      REG_END_CHARS:    modes.end_chars    = data[23:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_word();
    result_t want;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected (deliver %0h, last %0b)",
             out_deliver_byte, out_last);
      fail_count++;
    end else begin
      want = expected_words.pop_front();
      check_field("echo_count", 24'(want.echo_count), 24'(out_echo_count));
      check_field("echo_bytes", want.echo_bytes, out_echo_bytes);
      check_field("deliver_valid", 24'(want.deliver_valid), 24'(out_deliver_valid));
      check_field("deliver_byte", 24'(want.deliver_byte), 24'(out_deliver_byte));
      check_field("signal_valid", 24'(want.signal_valid), 24'(out_signal_valid));
      check_field("signal_kind", 24'(want.signal_kind), 24'(out_signal_kind));
      check_field("last", 24'(want.last), 24'(out_last));
      words_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      modes.input_modes  = INPUT_MODES_RST;
      modes.local_modes  = LOCAL_MODES_RST;
      modes.signal_chars = SIGNAL_CHARS_RST;
      modes.edit_chars   = EDIT_CHARS_RST;
      modes.end_chars    = END_CHARS_RST;
      line_fill = 0;
      expected_words.delete();
      fail_count    = 0;
      words_checked = 0;
    end else begin
      if (out_valid && !out_stall) check_word();
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) discipline_byte(in_rx_byte);
    end
    pending = expected_words.size();
  end

endmodule

>>> bench/terminal_line_discipline_tb.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline_tb
// Drives received bytes and mode register writes into the line discipline
// under random gaps and output stalls. A short directed opening touches the
// edit, signal and control characters; then, for each of several mode
// settings, random lines with edits, signals and terminators follow. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module terminal_line_discipline_tb;
  import tld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_BYTES  = 6;
  localparam logic [CFG_IDX_W-1:0] NO_SUCH_REG = 3'd7;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG   = 3'd5;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_echo_count;
  logic [23:0]           out_echo_bytes;
  logic                  out_deliver_valid;
  logic [7:0]            out_deliver_byte;
  logic                  out_signal_valid;
  logic [1:0]            out_signal_kind;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   pending;
  int   words_checked;
  int   rx_count;
  int   cfg_writes;
  int   settings_run;
  int   quiet_cycles;
  bit   no_gaps;
  cfg_t mode;

  terminal_line_discipline uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_echo_count   (out_echo_count),
    .out_echo_bytes   (out_echo_bytes),
    .out_deliver_valid(out_deliver_valid),
    .out_deliver_byte (out_deliver_byte),
    .out_signal_valid (out_signal_valid),
    .out_signal_kind  (out_signal_kind),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  line_discipline_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_echo_count   (out_echo_count),
    .out_echo_bytes   (out_echo_bytes),
    .out_deliver_valid(out_deliver_valid),
    .out_deliver_byte (out_deliver_byte),
    .out_signal_valid (out_signal_valid),
    .out_signal_kind  (out_signal_kind),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .words_checked    (words_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               IDLE_LIMIT, pending);
      $display("** terminal_line_discipline: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure: calm stretches, short blips and a few long holds
  initial begin : out_pacing
    int  pick;
    int  run;
    logic hold;
    out_stall = 1'b0;
    forever begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        hold = 1'b0;
        run  = $urandom_range(20, 60);
      end else if (pick == 1) begin
        hold = 1'b1;
        run  = $urandom_range(8, 30);
      end else begin
        hold = 1'($urandom_range(0, 1));
        run  = $urandom_range(1, 3);
      end
      repeat (run) begin
        @(negedge clk);
        out_stall <= hold;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 10) gap = 0;
    else if (r < 17) gap = $urandom_range(1, 2);
    else if (r < 19) gap = $urandom_range(3, 5);
    else gap = $urandom_range(10, 40);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    rx_count++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_modes(input logic [2:0] im, input logic [3:0] lm,
                               input logic [23:0] sc, input logic [15:0] ec,
                               input logic [23:0] xc);
    drain();
    cfg_write(REG_INPUT_MODES, 24'(im));
    cfg_write(REG_LOCAL_MODES, 24'(lm));
    cfg_write(REG_SIGNAL_CHARS, sc);
    cfg_write(REG_EDIT_CHARS, 24'(ec));
    cfg_write(REG_END_CHARS, xc);
    mode.input_modes  = im;
    mode.local_modes  = lm;
    mode.signal_chars = sc;
    mode.edit_chars   = ec;
    mode.end_chars    = xc;
    settings_run++;
  endtask

  // one typed line: text with edits, stray bytes and signals, then an ending or a random byte
  task automatic send_line();
    int         len;
    int         r;
    logic [7:0] b;
    no_gaps = ($urandom_range(0, 3) == 0);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 8) b = mode.edit_chars[7:0];
      else if (r < 11) b = mode.edit_chars[15:8];
      else if (r < 14) b = mode.signal_chars[8 * $urandom_range(0, 2) +: 8];
      else if (r < 24) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(32, 126));
      send_byte(b);
    end
    case ($urandom_range(0, 5))
      0: b = CH_NL;
      1: b = CH_CR;
      2: b = mode.end_chars[7:0];
      3: b = mode.end_chars[15:8];
      4: b = mode.end_chars[23:16];
      default: b = 8'($urandom_range(0, 255));
    endcase
    send_byte(b);
  endtask

  task automatic random_lines();
    int target;
    target = rx_count + PHASE_BYTES;
    while (rx_count < target) send_line();
  endtask

  initial begin : stimulus
    logic [7:0] opening [$];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    no_gaps    = 1'b0;
    rx_count   = 0;
    cfg_writes = 0;
    quiet_cycles = 0;
    settings_run = 1;
    mode.input_modes  = INPUT_MODES_RST;
    mode.local_modes  = LOCAL_MODES_RST;
    mode.signal_chars = SIGNAL_CHARS_RST;
    mode.edit_chars   = EDIT_CHARS_RST;
    mode.end_chars    = END_CHARS_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // erase on an empty line, NUL and top-bit bytes, every signal, kill, each ending
    opening = '{mode.edit_chars[7:0], 8'h00, 8'h7F, 8'h80, 8'hFF, mode.edit_chars[7:0],
                mode.signal_chars[7:0], mode.signal_chars[15:8], mode.signal_chars[23:16],
                CH_ESC, CH_TAB, CH_CR, 8'h6B, mode.edit_chars[15:8], 8'h65,
                mode.end_chars[7:0], CH_NL, 8'h1F, 8'h01, 8'h20, CH_NL};
    foreach (opening[k]) send_byte(opening[k]);
    random_lines();

    drain();
    cfg_write(NO_SUCH_REG, 24'hFFFFFF);
    program_modes(3'd1, 4'hF, SIGNAL_CHARS_RST, 16'h157F, 24'h3B2104);
    random_lines();
    program_modes(3'd4, 4'b1011, SIGNAL_CHARS_RST, EDIT_CHARS_RST, 24'h00210D);
    random_lines();
    program_modes(3'd0, 4'b0000, SIGNAL_CHARS_RST, EDIT_CHARS_RST, END_CHARS_RST);
    random_lines();
    program_modes(3'd7, 4'b0101, SIGNAL_CHARS_RST, EDIT_CHARS_RST, END_CHARS_RST);
    random_lines();
    program_modes(3'd3, 4'b1001, SIGNAL_CHARS_RST, EDIT_CHARS_RST, 24'h3B2104);
    random_lines();
    program_modes(3'd0, 4'hF, 24'h000000, 16'h0000, 24'h000000);
    random_lines();
    program_modes(3'd7, 4'hF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
    random_lines();
    drain();
    cfg_write(SPARE_REG, 24'($urandom));
    program_modes(3'($urandom), 4'($urandom), 24'($urandom), 16'($urandom), 24'($urandom));
    random_lines();

    drain();
    repeat (40) @(negedge clk);
    $display("checked %0d result words caused by %0d received bytes", words_checked, rx_count);
    $display("%0d register writes over %0d mode settings, raw and canonical, echo on and off",
             cfg_writes, settings_run);
    if (fail_count == 0) begin
      $display("** terminal_line_discipline: PASSED **");
    end else begin
      $display("** terminal_line_discipline: FAILED **");
    end
    $finish;
  end

endmodule

>>> terminal_line_discipline.f
hdl/tld_pkg.sv
hdl/tld_cfg_regs.sv
hdl/tld_line_ram.sv
hdl/tld_seq.sv
hdl/terminal_line_discipline.sv
bench/line_discipline_checker.sv
bench/terminal_line_discipline_tb.sv
